### rtl/irtf_pkg.sv
// Shared types and constants for the integer radix text formatter.
package irtf_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;

    typedef enum logic [1:0] {
        OP_DEC = 2'd0,
        OP_HEX = 2'd1,
        OP_BIN = 2'd2,
        OP_OCT = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CONV   = 5'b00010,
        ST_PREFIX = 5'b00100,
        ST_SKIP   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_B     = 7'h62;
    localparam logic [6:0] CH_NUL   = 7'h00;

endpackage

### rtl/integer_radix_text_formatter_unit.sv
// Integer to ASCII text formatter: signed decimal, hex, binary and octal, at most one character a cycle.
//
// Takes one number at a time and streams its text at most one character per cycle, most
// significant digit first, with last set on the final character. A number is accepted only
// while the unit is idle, so a new number waits until the last character of the one before
// has been issued. Hex, binary and octal text gives its prefix, then its digit slots
// (VALUE_BITS/4 rounded up, VALUE_BITS, VALUE_BITS/3 rounded up). Leading zero digits are
// stepped past one per cycle, and the skip then hands over to the output. Signed decimal
// first runs a bit-serial binary-to-BCD conversion over all VALUE_BITS bits of the magnitude,
// then gives the sign of a negative number, skips leading zero digits and outputs the digits.
// Output backpressure stalls the character stream, never the conversion.
module integer_radix_text_formatter_unit
#(
    parameter int VALUE_BITS = irtf_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [1:0]            operation,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  text_valid,
    input  logic                  text_ready,
    output logic [6:0]            character,
    output logic                  last
);

    import irtf_pkg::*;

    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int OCT_W      = OCT_DIGITS * 3;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic [DIG_W-1:0]        dig_reg, dig_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [13:0]             pfx_reg, pfx_next;
    logic [1:0]              pfx_cnt_reg, pfx_cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [6:0]              char_reg, char_next;
    logic                    last_reg, last_next;

    op_t                     op_in;
    logic                    neg_in;
    logic                    out_free;
    logic [3:0]              top_digit;
    logic [6:0]              digit_char;
    logic [DIG_W-1:0]        dig_shifted;
    logic [DIG_W-1:0]        bcd_adj;
    logic [3:0]              nib;

    assign op_in    = op_t'(operation);
    assign neg_in   = value[VALUE_BITS-1];
    assign out_free = !out_valid_reg || text_ready;

    assign item_ready = (state_reg == ST_IDLE);
    assign text_valid = out_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;

    // Top digit of the aligned digit register, by radix width
    always_comb
    begin
        case (op_reg)
            OP_BIN:
            begin
                top_digit   = {3'b000, dig_reg[DIG_W-1]};
                dig_shifted = dig_reg << 1;
            end
            OP_OCT:
            begin
                top_digit   = {1'b0, dig_reg[DIG_W-1 -: 3]};
                dig_shifted = dig_reg << 3;
            end
            default:
            begin
                top_digit   = dig_reg[DIG_W-1 -: 4];
                dig_shifted = dig_reg << 4;
            end
        endcase
        if (top_digit <= 4'd9)
        begin
            digit_char = CH_ZERO + 7'(top_digit);
        end
        else
        begin
            digit_char = CH_A + 7'(top_digit) - 7'd10;
        end
    end

    // Double dabble correction: add three to every BCD digit of five or more
    always_comb
    begin
        nib = 4'd0;
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            nib = dig_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        mag_next       = mag_reg;
        dig_next       = dig_reg;
        cnt_next       = cnt_reg;
        pfx_next       = pfx_reg;
        pfx_cnt_next   = pfx_cnt_reg;
        out_valid_next = out_valid_reg && !text_ready;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op_next = op_in;
                    unique case (op_in)
                        OP_DEC:
                        begin
                            mag_next     = neg_in ? (~value + VALUE_BITS'(1)) : value;
                            dig_next     = '0;
                            cnt_next     = CNT_W'(VALUE_BITS);
                            pfx_next     = {CH_MINUS, CH_NUL};
                            pfx_cnt_next = neg_in ? 2'd1 : 2'd0;
                            state_next   = ST_CONV;
                        end
                        OP_HEX:
                        begin
                            dig_next     = DIG_W'(value) << (DIG_W - HEX_W);
                            cnt_next     = CNT_W'(HEX_DIGITS);
                            pfx_next     = {CH_ZERO, CH_X};
                            pfx_cnt_next = 2'd2;
                            state_next   = ST_PREFIX;
                        end
                        OP_BIN:
                        begin
                            dig_next     = DIG_W'(value) << (DIG_W - VALUE_BITS);
                            cnt_next     = CNT_W'(VALUE_BITS);
                            pfx_next     = {CH_ZERO, CH_B};
                            pfx_cnt_next = 2'd2;
                            state_next   = ST_PREFIX;
                        end
                        OP_OCT:
                        begin
                            dig_next     = DIG_W'(value) << (DIG_W - OCT_W);
                            cnt_next     = CNT_W'(OCT_DIGITS);
                            pfx_next     = {CH_ZERO, CH_NUL};
                            pfx_cnt_next = 2'd1;
                            state_next   = ST_PREFIX;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                // Correct, then shift in the next magnitude bit
                dig_next = {bcd_adj[DIG_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next = mag_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next   = CNT_W'(DEC_DIGITS);
                    state_next = (pfx_cnt_reg != 2'd0) ? ST_PREFIX : ST_SKIP;
                end
            end
            ST_PREFIX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = pfx_reg[13:7];
                    last_next      = 1'b0;
                    pfx_next       = {pfx_reg[6:0], CH_NUL};
                    pfx_cnt_next   = pfx_cnt_reg - 2'd1;
                    if (pfx_cnt_reg == 2'd1)
                    begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP:
            begin
                // Drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && cnt_reg != CNT_W'(1))
                begin
                    dig_next = dig_shifted;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char;
                    last_next      = (cnt_reg == CNT_W'(1));
                    dig_next       = dig_shifted;
                    cnt_next       = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            pfx_cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            pfx_cnt_reg   <= pfx_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        mag_reg  <= mag_next;
        dig_reg  <= dig_next;
        pfx_reg  <= pfx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule
